/* hw/rtl/iqbq_pkg.sv */
// Shared types, constants and coefficient table for the I/Q biquad decimator.
// No dependencies; used by iqbq_lane, iqbq_merge and iq_biquad_decimate_by_four.

package iqbq_pkg;

  localparam int SAMPLE_WIDTH       = 16;
  localparam int DECIMATION_FACTOR  = 4;
  localparam int SECTION_COUNT      = 2;
  localparam int COEF_FRACTION_BITS = 20;

  localparam int GUARD_BITS  = 8;
  localparam int TABLE_FRAC  = 28;
  localparam int SIG_W       = 32;
  localparam int COEF_W      = COEF_FRACTION_BITS + 4;
  localparam int PROD_W      = SIG_W + COEF_W;
  localparam int ACC_W       = 64;
  localparam int TAPS        = 5;
  localparam int SEC_W       = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int DEC_W       = $clog2(DECIMATION_FACTOR);

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'sd1 <<< (COEF_FRACTION_BITS - 1));
  localparam longint SIG_MAX = (longint'(1) <<< (SIG_W - 1)) - 1;
  localparam longint SIG_MIN = -(longint'(1) <<< (SIG_W - 1));
  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

  typedef enum logic [2:0] {
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2,
    TAP_X
  } tap_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [SEC_W-1:0] sec;
    tap_e             tap;
  } lane_ctrl_t;

  typedef struct packed {
    logic valid;
    logic block_start;
  } res_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] x1;
    logic signed [SIG_W-1:0] x2;
    logic signed [SIG_W-1:0] y1;
    logic signed [SIG_W-1:0] y2;
  } hist_t;

  // Q4.28 to Q(COEF_FRACTION_BITS), rounded half away from zero
  function automatic logic signed [COEF_W-1:0] round_coef(longint c);
    longint mag;
    int     s;
    s   = TABLE_FRAC - COEF_FRACTION_BITS;
    mag = (c < 0) ? -c : c;
    if (s > 0) begin
      mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
    end
    return COEF_W'((c < 0) ? -mag : mag);
  endfunction

  // Feedback taps hold the negated a1, a2 so every tap adds
  localparam logic signed [COEF_W-1:0] B0_S0  = round_coef(64'sd1295025);
  localparam logic signed [COEF_W-1:0] B1_S0  = round_coef(64'sd2590070);
  localparam logic signed [COEF_W-1:0] B2_S0  = round_coef(64'sd1295025);
  localparam logic signed [COEF_W-1:0] NA1_S0 = round_coef(64'sd281481419);
  localparam logic signed [COEF_W-1:0] NA2_S0 = round_coef(-64'sd79494583);
  localparam logic signed [COEF_W-1:0] B0_S1  = round_coef(64'sd268435456);
  localparam logic signed [COEF_W-1:0] B1_S1  = round_coef(64'sd536870912);
  localparam logic signed [COEF_W-1:0] B2_S1  = round_coef(64'sd268435456);
  localparam logic signed [COEF_W-1:0] NA1_S1 = round_coef(64'sd354579883);
  localparam logic signed [COEF_W-1:0] NA2_S1 = round_coef(-64'sd169849528);

  function automatic logic signed [COEF_W-1:0] coef_sel(logic set, tap_e tap);
    logic signed [COEF_W-1:0] c;
    case (tap)
      TAP_X:   c = set ? B0_S1  : B0_S0;
      TAP_X1:  c = set ? B1_S1  : B1_S0;
      TAP_X2:  c = set ? B2_S1  : B2_S0;
      TAP_Y1:  c = set ? NA1_S1 : NA1_S0;
      TAP_Y2:  c = set ? NA2_S1 : NA2_S0;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/iqbq_lane.sv */
// One channel lane: section history, one shared multiplier and accumulator.
// Depends on iqbq_pkg; driven by the sequencer in iq_biquad_decimate_by_four.

module iqbq_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iqbq_pkg::lane_ctrl_t                  ctrl_i,
  input  logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [iqbq_pkg::SIG_W-1:0]     y_o
);

  iqbq_pkg::hist_t hist_q [iqbq_pkg::SECTION_COUNT];
  iqbq_pkg::hist_t hist_d [iqbq_pkg::SECTION_COUNT];

  logic signed [iqbq_pkg::SIG_W-1:0]  x_cur_q, x_cur_d;
  logic signed [iqbq_pkg::SIG_W-1:0]  operand;
  logic signed [iqbq_pkg::COEF_W-1:0] coef;
  logic signed [iqbq_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                               prod_valid_q, prod_first_q, prod_last_q;
  logic [iqbq_pkg::SEC_W-1:0]         prod_sec_q;
  logic signed [iqbq_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [iqbq_pkg::ACC_W-1:0]  sum;
  logic signed [iqbq_pkg::ACC_W-1:0]  y_full;
  logic signed [iqbq_pkg::SIG_W-1:0]  y_sat;

  always_comb begin
    case (ctrl_i.tap)
      iqbq_pkg::TAP_X1: operand = hist_q[ctrl_i.sec].x1;
      iqbq_pkg::TAP_X2: operand = hist_q[ctrl_i.sec].x2;
      iqbq_pkg::TAP_Y1: operand = hist_q[ctrl_i.sec].y1;
      iqbq_pkg::TAP_Y2: operand = hist_q[ctrl_i.sec].y2;
      iqbq_pkg::TAP_X:  operand = x_cur_q;
      default:          operand = '0;
    endcase
    coef   = iqbq_pkg::coef_sel(ctrl_i.sec[0], ctrl_i.tap);
    prod_d = iqbq_pkg::PROD_W'(operand) * iqbq_pkg::PROD_W'(coef);
  end

  always_comb begin
    sum    = (prod_first_q ? iqbq_pkg::ACC_RND : acc_q) + iqbq_pkg::ACC_W'(prod_q);
    y_full = sum >>> iqbq_pkg::COEF_FRACTION_BITS;
    if (y_full > iqbq_pkg::ACC_W'(iqbq_pkg::SIG_MAX)) begin
      y_sat = iqbq_pkg::SIG_W'(iqbq_pkg::SIG_MAX);
    end else if (y_full < iqbq_pkg::ACC_W'(iqbq_pkg::SIG_MIN)) begin
      y_sat = iqbq_pkg::SIG_W'(iqbq_pkg::SIG_MIN);
    end else begin
      y_sat = iqbq_pkg::SIG_W'(y_full);
    end

    acc_d   = acc_q;
    x_cur_d = x_cur_q;
    hist_d  = hist_q;
    if (prod_valid_q) begin
      acc_d = sum;
      if (prod_last_q) begin
        hist_d[prod_sec_q].x2 = hist_q[prod_sec_q].x1;
        hist_d[prod_sec_q].x1 = x_cur_q;
        hist_d[prod_sec_q].y2 = hist_q[prod_sec_q].y1;
        hist_d[prod_sec_q].y1 = y_sat;
        x_cur_d               = y_sat;
      end
    end
    if (ctrl_i.load) begin
      x_cur_d = iqbq_pkg::SIG_W'(sample_i) <<< iqbq_pkg::GUARD_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q       <= '{default: '0};
      prod_valid_q <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
      prod_sec_q   <= '0;
    end else begin
      hist_q       <= hist_d;
      prod_valid_q <= ctrl_i.issue;
      prod_first_q <= ctrl_i.tap == iqbq_pkg::TAP_X1;
      prod_last_q  <= ctrl_i.tap == iqbq_pkg::TAP_X;
      prod_sec_q   <= ctrl_i.sec;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    x_cur_q <= x_cur_d;
  end

  assign y_o = x_cur_q;

  a_load_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |-> !prod_valid_q)
    else $error("lane loads a new item while the accumulator is busy");

  a_section_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_valid_q && prod_last_q |=> !prod_valid_q || prod_first_q)
    else $error("product after section end does not open a section");

endmodule

/* hw/rtl/iqbq_merge.sv */
// Merging stage: rounds both lane results, keeps one pair in four from each block start, output register.
// Depends on iqbq_pkg; fed by the two iqbq_lane instances.

module iqbq_merge (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  iqbq_pkg::res_t                           res_i,
  input  logic signed [iqbq_pkg::SIG_W-1:0]        y_in_phase_i,
  input  logic signed [iqbq_pkg::SIG_W-1:0]        y_quadrature_i,
  input  logic                                     out_stall_i,
  output logic                                     take_o,
  output logic                                     out_valid_o,
  output logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] in_phase_out_o,
  output logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] quadrature_out_o
);

  localparam int RW = iqbq_pkg::SIG_W + 1 - iqbq_pkg::GUARD_BITS;

  function automatic logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] to_sample(
    logic signed [iqbq_pkg::SIG_W-1:0] y
  );
    logic signed [iqbq_pkg::SIG_W:0] r;
    logic signed [RW-1:0]            t;
    logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] s;
    r = (iqbq_pkg::SIG_W + 1)'(y) + (iqbq_pkg::SIG_W + 1)'(1 << (iqbq_pkg::GUARD_BITS - 1));
    t = RW'(r >>> iqbq_pkg::GUARD_BITS);
    if (t > RW'(iqbq_pkg::OUT_MAX)) begin
      s = iqbq_pkg::SAMPLE_WIDTH'(iqbq_pkg::OUT_MAX);
    end else if (t < RW'(iqbq_pkg::OUT_MIN)) begin
      s = iqbq_pkg::SAMPLE_WIDTH'(iqbq_pkg::OUT_MIN);
    end else begin
      s = iqbq_pkg::SAMPLE_WIDTH'(t);
    end
    return s;
  endfunction

  logic [iqbq_pkg::DEC_W-1:0] phase_q, phase_d, phase_base;
  logic                       emit;
  logic                       out_valid_q, out_valid_d;
  logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] i_out_q, q_out_q;

  always_comb begin
    phase_base = res_i.block_start ? '0 : phase_q;
    emit       = phase_base == '0;
    take_o     = res_i.valid && (!emit || !out_valid_q || !out_stall_i);
    phase_d    = phase_q;
    if (take_o) begin
      if (phase_base == iqbq_pkg::DEC_W'(iqbq_pkg::DECIMATION_FACTOR - 1)) begin
        phase_d = '0;
      end else begin
        phase_d = phase_base + iqbq_pkg::DEC_W'(1);
      end
    end
    out_valid_d = out_valid_q;
    if (take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      i_out_q <= to_sample(y_in_phase_i);
      q_out_q <= to_sample(y_quadrature_i);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign in_phase_out_o   = i_out_q;
  assign quadrature_out_o = q_out_q;

  a_emit_from_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(take_o))
    else $error("output item appears without a taken lane result");

endmodule

/* hw/rtl/iq_biquad_decimate_by_four.sv */
// Items are taken one at a time, in idle or in hand-off once the last result is taken.
// Each lane's single 24x32 multiplier runs 5 taps for each of 2 sections (run state),
// then come the drain and hand-off states; a kept result goes to the output register.
// Reset clears filter history, decimation phase and the output valid flag.
// Top level: sequencer, two iqbq_lane instances and iqbq_merge; depends on iqbq_pkg.

module iq_biquad_decimate_by_four (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] in_phase_in_i,
  input  logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] quadrature_in_i,
  input  logic                                     block_start_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] in_phase_out_o,
  output logic signed [iqbq_pkg::SAMPLE_WIDTH-1:0] quadrature_out_o
);

  localparam logic [iqbq_pkg::SEC_W-1:0] SEC_LAST =
    iqbq_pkg::SEC_W'(iqbq_pkg::SECTION_COUNT - 1);

  iqbq_pkg::state_e           state_q, state_d;
  logic [iqbq_pkg::SEC_W-1:0] sec_q, sec_d;
  iqbq_pkg::tap_e             tap_q, tap_d;
  iqbq_pkg::lane_ctrl_t       ctrl;
  iqbq_pkg::res_t             res;
  logic                       in_acc;
  logic                       take;
  logic                       blk_q;
  logic signed [iqbq_pkg::SIG_W-1:0] y_i, y_q;

  function automatic iqbq_pkg::tap_e next_tap(iqbq_pkg::tap_e t);
    iqbq_pkg::tap_e n;
    case (t)
      iqbq_pkg::TAP_X1: n = iqbq_pkg::TAP_X2;
      iqbq_pkg::TAP_X2: n = iqbq_pkg::TAP_Y1;
      iqbq_pkg::TAP_Y1: n = iqbq_pkg::TAP_Y2;
      iqbq_pkg::TAP_Y2: n = iqbq_pkg::TAP_X;
      default:          n = iqbq_pkg::TAP_X1;
    endcase
    return n;
  endfunction

  always_comb begin
    res.valid       = state_q == iqbq_pkg::ST_DONE;
    res.block_start = blk_q;
  end

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    tap_d       = tap_q;
    in_stall_o  = 1'b1;
    ctrl.issue  = 1'b0;
    case (state_q)
      iqbq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = iqbq_pkg::ST_RUN;
          sec_d   = '0;
          tap_d   = iqbq_pkg::TAP_X1;
        end
      end
      iqbq_pkg::ST_RUN: begin
        ctrl.issue = 1'b1;
        if (tap_q == iqbq_pkg::TAP_X) begin
          tap_d = iqbq_pkg::TAP_X1;
          if (sec_q == SEC_LAST) begin
            state_d = iqbq_pkg::ST_DRAIN;
          end else begin
            sec_d = sec_q + iqbq_pkg::SEC_W'(1);
          end
        end else begin
          tap_d = next_tap(tap_q);
        end
      end
      iqbq_pkg::ST_DRAIN: begin
        state_d = iqbq_pkg::ST_DONE;
      end
      iqbq_pkg::ST_DONE: begin
        in_stall_o = !take;
        if (take) begin
          if (in_valid_i) begin
            state_d = iqbq_pkg::ST_RUN;
            sec_d   = '0;
            tap_d   = iqbq_pkg::TAP_X1;
          end else begin
            state_d = iqbq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = iqbq_pkg::ST_IDLE;
      end
    endcase
    in_acc          = in_valid_i && !in_stall_o;
    ctrl.load       = in_acc;
    ctrl.sec        = sec_q;
    ctrl.tap        = tap_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iqbq_pkg::ST_IDLE;
      sec_q   <= '0;
      tap_q   <= iqbq_pkg::TAP_X1;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      tap_q   <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q <= block_start_i;
    end
  end

  iqbq_lane u_lane_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_phase_in_i),
    .y_o      (y_i)
  );

  iqbq_lane u_lane_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (quadrature_in_i),
    .y_o      (y_q)
  );

  iqbq_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_i            (res),
    .y_in_phase_i     (y_i),
    .y_quadrature_i   (y_q),
    .out_stall_i      (out_stall_i),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .in_phase_out_o   (in_phase_out_o),
    .quadrature_out_o (quadrature_out_o)
  );

  a_accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == iqbq_pkg::ST_IDLE || state_q == iqbq_pkg::ST_DONE)
    else $error("item accepted while lanes are busy");

  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##(iqbq_pkg::SECTION_COUNT * iqbq_pkg::TAPS + 2)
      state_q == iqbq_pkg::ST_DONE)
    else $error("lane result not ready on schedule");

endmodule

/* verif/tb_iq_biquad_decimate_by_four.sv */
// Testbench for iq_biquad_decimate_by_four: directed and random I/Q items with random idling,
// each result checked against a bit-exact cascaded biquad and decimation predictor.
// Depends on iqbq_pkg and the iq_biquad_decimate_by_four RTL.
`timescale 1ns / 100ps

module tb_iq_biquad_decimate_by_four;

  localparam int SW     = iqbq_pkg::SAMPLE_WIDTH;
  localparam int NSEC   = iqbq_pkg::SECTION_COUNT;
  localparam int DEC    = iqbq_pkg::DECIMATION_FACTOR;
  localparam int FRAC   = iqbq_pkg::COEF_FRACTION_BITS;
  localparam int GUARD  = 8;
  localparam int ITEMS  = 900;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum int {
    MODE_NOISE,
    MODE_EXTREME,
    MODE_WALK
  } stim_mode_e;

  class biquad_decimator_model;
    typedef struct {
      logic signed [SW-1:0] i_s;
      logic signed [SW-1:0] q_s;
    } pair_t;

    longint coef[2][5];
    longint hist[2][NSEC][4];
    int     phase;
    int     failures;
    pair_t  pending_pairs[$];

    function new();
      longint q28[2][5];
      q28[0] = '{1295025, 2590070, 1295025, -281481419, 79494583};
      q28[1] = '{268435456, 536870912, 268435456, -354579883, 169849528};
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 5; k++) begin
          coef[s][k] = rescale(q28[s][k]);
        end
      end
      for (int c = 0; c < 2; c++) begin
        for (int s = 0; s < NSEC; s++) begin
          for (int k = 0; k < 4; k++) begin
            hist[c][s][k] = 0;
          end
        end
      end
      phase    = 0;
      failures = 0;
    endfunction

    static function longint rescale(longint c);
      int     sh;
      longint mag;
      sh  = 28 - FRAC;
      mag = (c < 0) ? -c : c;
      if (sh > 0) begin
        mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
      end
      return (c < 0) ? -mag : mag;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint run_section(int ch, int sec, longint x);
      int     cs;
      longint acc;
      longint y;
      cs  = sec % 2;
      acc = coef[cs][0] * x + coef[cs][1] * hist[ch][sec][0] + coef[cs][2] * hist[ch][sec][1]
          - coef[cs][3] * hist[ch][sec][2] - coef[cs][4] * hist[ch][sec][3];
      y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      y = clamp(y, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
      hist[ch][sec][1] = hist[ch][sec][0];
      hist[ch][sec][0] = x;
      hist[ch][sec][3] = hist[ch][sec][2];
      hist[ch][sec][2] = y;
      return y;
    endfunction

    function logic signed [SW-1:0] run_channel(int ch, logic signed [SW-1:0] smp);
      longint v;
      v = longint'(smp) <<< GUARD;
      for (int s = 0; s < NSEC; s++) begin
        v = run_section(ch, s, v);
      end
      v = (v + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
      v = clamp(v, longint'(S_MIN), longint'(S_MAX));
      return SW'(v);
    endfunction

    function void filter_sample(logic signed [SW-1:0] i_s, logic signed [SW-1:0] q_s,
                                logic bs);
      pair_t p;
      p.i_s = run_channel(0, i_s);
      p.q_s = run_channel(1, q_s);
      if (bs) begin
        phase = 0;
      end
      if (phase == 0) begin
        pending_pairs.push_back(p);
      end
      phase = (phase + 1) % DEC;
    endfunction

    function void check_pair(logic signed [SW-1:0] i_a, logic signed [SW-1:0] q_a);
      pair_t p;
      if (pending_pairs.size() == 0) begin
        $error("unexpected result in_phase_out %0d quadrature_out %0d", i_a, q_a);
        failures++;
        return;
      end
      p = pending_pairs.pop_front();
      if (i_a !== p.i_s) begin
        $error("in_phase_out expected %0d actual %0d", p.i_s, i_a);
        failures++;
      end
      if (q_a !== p.q_s) begin
        $error("quadrature_out expected %0d actual %0d", p.q_s, q_a);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] in_i = '0;
  logic signed [SW-1:0] in_q = '0;
  logic                 in_bs = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] out_i;
  logic signed [SW-1:0] out_q;

  biquad_decimator_model model = new();
  bit                    idle_on = 1'b1;
  int                    stall_left = 0;
  int                    sent = 0;

  iq_biquad_decimate_by_four dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_phase_in_i    (in_i),
    .quadrature_in_i  (in_q),
    .block_start_i    (in_bs),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .in_phase_out_o   (out_i),
    .quadrature_out_o (out_q)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      model.filter_sample(in_i, in_q, in_bs);
    end
    if (rst_n && out_valid && !out_stall) begin
      model.check_pair(out_i, out_q);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic drive_pair(logic signed [SW-1:0] i_s, logic signed [SW-1:0] q_s, logic bs);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_i     <= i_s;
    in_q     <= q_s;
    in_bs    <= bs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drive_block(stim_mode_e mode, int len);
    logic signed [SW-1:0] i_s;
    logic signed [SW-1:0] q_s;
    logic                 bs;
    int                   wi;
    int                   wq;
    int                   hold;
    wi   = $urandom_range(0, 65535) - 32768;
    wq   = $urandom_range(0, 65535) - 32768;
    hold = 0;
    i_s  = S_MAX;
    q_s  = S_MIN;
    for (int k = 0; k < len; k++) begin
      bs = (k == 0) || ($urandom_range(0, 39) == 0);
      case (mode)
        MODE_NOISE: begin
          i_s = SW'($urandom);
          q_s = SW'($urandom);
        end
        MODE_EXTREME: begin
          if (hold == 0) begin
            hold = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0: i_s = S_MAX;
              1: i_s = S_MIN;
              2: i_s = -i_s;
              default: i_s = SW'($urandom);
            endcase
            q_s = ($urandom_range(0, 1) != 0) ? ~i_s : i_s;
          end
          hold--;
        end
        default: begin
          wi  = wi + $urandom_range(0, 4095) - 2048;
          wi  = (wi > 32767) ? 32767 : ((wi < -32768) ? -32768 : wi);
          wq  = wq + $urandom_range(0, 4095) - 2048;
          wq  = (wq > 32767) ? 32767 : ((wq < -32768) ? -32768 : wq);
          i_s = SW'(wi);
          q_s = SW'(wq);
        end
      endcase
      drive_pair(i_s, q_s, bs);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_pair('0, '0, 1'b1);
    repeat (6) drive_pair(S_MAX, S_MIN, 1'b0);
    repeat (6) drive_pair(S_MIN, S_MAX, 1'b0);
    for (int k = 0; k < 4; k++) begin
      drive_pair((k % 2) ? S_MIN : S_MAX, (k % 2) ? S_MAX : S_MIN, 1'b0);
    end
    repeat (3) drive_pair(S_MAX, S_MAX, 1'b1);
    drive_pair(16'sh5555, -16'sh5556, 1'b0);
    drive_pair(-16'sh5556, 16'sh5555, 1'b0);
    drive_pair(16'sd1, -16'sd1, 1'b1);

    while (sent < ITEMS) begin
      if (sent % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (sent > ITEMS - 150) begin
        idle_on = 1'b0;
      end
      case ($urandom_range(0, 2))
        0: drive_block(MODE_NOISE, $urandom_range(1, 24));
        1: drive_block(MODE_EXTREME, $urandom_range(20, 90));
        default: drive_block(MODE_WALK, $urandom_range(4, 60));
      endcase
    end
    in_valid <= 1'b0;

    while (model.pending_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (model.pending_pairs.size() != 0) begin
      $error("%0d expected results never arrived", model.pending_pairs.size());
      model.failures++;
    end
    if (model.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("FAIL");
    $finish;
  end

endmodule
